/* hdl/pnft_pkg.sv */
package pnft_pkg;

  // history ring and sorted copy
  localparam int HIST_DEPTH = 64;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = HIST_AW + 1;

  // field and register widths
  localparam int ENERGY_BITS = 32;
  localparam int BPE_W       = 10;
  localparam int SUM_W       = ENERGY_BITS + BPE_W;
  localparam int MINE_W      = 7;
  localparam int TMO_W       = 16;
  localparam int TIME_W      = 32;
  localparam int EST_W       = 32;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 16;

  // register reset values
  localparam logic [BPE_W-1:0]  BPE_RST  = BPE_W'(16);
  localparam logic [MINE_W-1:0] MINE_RST = MINE_W'(10);
  localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(5000);

  // register indexes
  localparam logic [CFG_AW-1:0] REG_BPE  = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_MINE = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_TMO  = CFG_AW'(2);

  // commands
  localparam logic CMD_RESTART = 1'b1;

  // 1.05 in q10, reject factor 5
  localparam int BIAS_Q10      = 1075;
  localparam int BIAS_W        = 11;
  localparam int BIAS_SHIFT    = 10;
  localparam int REJECT_FACTOR = 5;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_STORED   = 2'd1,
    EV_REJECTED = 2'd2
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_WRITE,
    ST_FIND,
    ST_MOVE,
    ST_RANK,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

/* hdl/percentile_noise_floor_tracker.sv */
// ch  | handshake         | tdata                              | tuser
// in  | in_tvalid/tready  | [31:0] block_energy [63:32] now_ms | [0] command
// out | out_tvalid/tready | [31:0] noise_estimate              | [0] ready_res [2:1] entry_event
// cfg | cfg_we, no wait   | cfg_addr index, cfg_wdata value    | -
//
// one item in work at a time; a sample that completes no entry, or a restart, goes straight
// to the result; a completed entry is first averaged in the serial divider and tested for
// rejection; a stored entry is written to the ring, in a full ring the replaced entry is found
// in the sorted copy, then the new one slides in, one sorted-copy access per cycle
// reset is synchronous, active low; no clearing pass, history is read only where written
// the result register lets the next item in while a result still waits on out_tready
module percentile_noise_floor_tracker import pnft_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,   // [31:0] block_energy, [63:32] now_ms
  input  logic [0:0]          in_tuser,   // [0] command
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // [31:0] noise_estimate
  output logic [2:0]          out_tuser,  // [0] ready_res, [2:1] entry_event
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  // configuration
  logic [BPE_W-1:0]  bpe_r;
  logic [MINE_W-1:0] mine_r;
  logic [TMO_W-1:0]  tmo_r;

  // tracker state
  logic [SUM_W-1:0]   sum_r;
  logic [BPE_W-1:0]   bcnt_r;
  logic [HIST_AW-1:0] wi_r;
  logic [CNT_W-1:0]   ec_r;
  logic               running_r;
  logic [EST_W-1:0]   est_r;
  logic [TIME_W-1:0]  last_r;

  state_t state_r, state_nxt;
  event_t event_r;

  // per-item work registers
  logic [TIME_W-1:0]  now_r;
  logic [BPE_W-1:0]   dvs_r;
  logic [BPE_W-1:0]   rem_r;
  logic [SUM_W-1:0]   quo_r;
  logic [DIV_CW-1:0]  dstep_r;
  logic [EST_W-1:0]   avg_r;
  logic [EST_W-1:0]   old_r;
  logic               dir_up_r;
  logic [HIST_AW-1:0] pos_r;
  logic [HIST_AW-1:0] fi_r;

  // output register
  logic               out_valid_r;
  logic [EST_W-1:0]   out_est_r;
  logic               out_ready_r;
  event_t             out_event_r;

  // history ring and its sorted copy, registered reads
  logic [EST_W-1:0]   hist_mem [HIST_DEPTH];
  logic [EST_W-1:0]   hist_q_r;
  logic [EST_W-1:0]   sort_mem [HIST_DEPTH];
  logic [EST_W-1:0]   sort_q_r;

  logic               hist_we;
  logic [HIST_AW-1:0] sort_rd_addr;
  logic               sort_we;
  logic [HIST_AW-1:0] sort_wr_addr;
  logic [EST_W-1:0]   sort_wr_data;

  // input fields
  logic               cmd;
  logic [ENERGY_BITS-1:0] energy;
  logic [TIME_W-1:0]  now_in;
  logic               accept;

  assign cmd    = in_tuser[0];
  assign energy = in_tdata[ENERGY_BITS-1:0];
  assign now_in = in_tdata[63:32];
  assign accept = in_tvalid && in_tready;

  // accumulate
  logic [SUM_W-1:0]  sum_add;
  logic [BPE_W-1:0]  bcnt_inc;
  logic [BPE_W-1:0]  need;
  logic              entry_done;

  assign sum_add    = sum_r + SUM_W'(energy);
  assign bcnt_inc   = bcnt_r + BPE_W'(1);
  assign need       = (bpe_r == '0) ? BPE_W'(1) : bpe_r;
  assign entry_done = (bcnt_inc >= need);

  // entries needed before the first estimate, clamped to 1..depth
  logic [CNT_W-1:0] lim;
  always_comb begin
    if (mine_r == '0) lim = CNT_W'(1);
    else if (CNT_W'(mine_r) > CNT_W'(HIST_DEPTH)) lim = CNT_W'(HIST_DEPTH);
    else lim = CNT_W'(mine_r);
  end

  // restoring divider step
  logic [BPE_W:0]   trial;
  logic             div_ge;
  logic [BPE_W-1:0] rem_step;
  logic [SUM_W-1:0] quo_step;

  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign div_ge   = (trial >= {1'b0, dvs_r});
  assign rem_step = div_ge ? BPE_W'(trial - {1'b0, dvs_r}) : BPE_W'(trial);
  assign quo_step = {quo_r[SUM_W-2:0], div_ge};

  // outlier and timeout test
  logic [EST_W+2:0]  est_x5;
  logic              outlier;
  logic              fresh;
  logic              reject;

  assign est_x5  = {3'b000, est_r} * (EST_W+3)'(REJECT_FACTOR);
  assign outlier = ({3'b000, avg_r} > est_x5);
  assign fresh   = ({1'b0, now_r} < ({1'b0, last_r} + (TIME_W+1)'(tmo_r)));
  assign reject  = running_r && outlier && fresh;

  // sorted copy maintenance: in a full ring find the replaced entry, then slide the new one in
  logic              match;
  logic              go_up;
  logic              at_end;
  logic              slide;

  assign match  = (sort_q_r == old_r);
  assign go_up  = (avg_r >= old_r);
  assign at_end = dir_up_r ? (pos_r == HIST_AW'(HIST_DEPTH - 1)) : (pos_r == '0);
  assign slide  = !at_end && (dir_up_r ? (sort_q_r < avg_r) : (sort_q_r > avg_r));

  // percentile rank floor(n * 25 / 100) is n / 4
  logic [HIST_AW-1:0] rank;
  assign rank = HIST_AW'(ec_r >> 2);

  // scale by 1.05 and saturate
  logic [EST_W+BIAS_W-1:0] prod;
  logic [EST_W:0]          scaled;
  logic [EST_W-1:0]        est_new;

  assign prod    = (EST_W+BIAS_W)'(sort_q_r) * (EST_W+BIAS_W)'(BIAS_Q10);
  assign scaled  = (EST_W+1)'(prod >> BIAS_SHIFT);
  assign est_new = scaled[EST_W] ? '1 : scaled[EST_W-1:0];

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_RESTART || !entry_done) state_nxt = ST_DONE;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dstep_r == DIV_CW'(DIV_STEPS - 1)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: state_nxt = reject ? ST_DONE : ST_WRITE;
      ST_WRITE: state_nxt = (ec_r == CNT_W'(HIST_DEPTH)) ? ST_FIND : ST_MOVE;
      ST_FIND: begin
        if (match) state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        if (!slide) state_nxt = ST_RANK;
      end
      ST_RANK: state_nxt = (running_r || ec_r >= lim) ? ST_SCALE : ST_DONE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_tready    = 1'b0;
    hist_we      = 1'b0;
    sort_rd_addr = fi_r;
    sort_we      = 1'b0;
    sort_wr_addr = pos_r;
    sort_wr_data = avg_r;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_WRITE: begin
        hist_we = 1'b1;
        // full ring: start the search at slot 0, else read below the free slot
        sort_rd_addr = (ec_r == CNT_W'(HIST_DEPTH)) ? '0 : HIST_AW'(ec_r - CNT_W'(1));
      end
      ST_FIND: begin
        if (match) sort_rd_addr = go_up ? fi_r + HIST_AW'(1) : fi_r - HIST_AW'(1);
        else sort_rd_addr = fi_r + HIST_AW'(1);
      end
      ST_MOVE: begin
        sort_we      = 1'b1;
        sort_wr_data = slide ? sort_q_r : avg_r;
        // read one slot ahead of the one being written next
        sort_rd_addr = dir_up_r ? pos_r + HIST_AW'(2) : pos_r - HIST_AW'(2);
      end
      ST_RANK: sort_rd_addr = rank;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[wi_r] <= avg_r;
    hist_q_r <= hist_mem[wi_r];
  end

  always_ff @(posedge clk) begin
    if (sort_we) sort_mem[sort_wr_addr] <= sort_wr_data;
    sort_q_r <= sort_mem[sort_rd_addr];
  end

  // control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bpe_r       <= BPE_RST;
      mine_r      <= MINE_RST;
      tmo_r       <= TMO_RST;
      sum_r       <= '0;
      bcnt_r      <= '0;
      wi_r        <= '0;
      ec_r        <= '0;
      running_r   <= 1'b0;
      est_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_BPE:  bpe_r  <= cfg_wdata[BPE_W-1:0];
          REG_MINE: mine_r <= cfg_wdata[MINE_W-1:0];
          REG_TMO:  tmo_r  <= cfg_wdata[TMO_W-1:0];
          default:  ;
        endcase
      end

      // a new result replaces the one taken in the same cycle
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (cmd == CMD_RESTART) begin
              sum_r     <= '0;
              bcnt_r    <= '0;
              wi_r      <= '0;
              ec_r      <= '0;
              running_r <= 1'b0;
              est_r     <= '0;
              last_r    <= '0;
            end else if (entry_done) begin
              // entry completes: accumulator is free again
              sum_r  <= '0;
              bcnt_r <= '0;
            end else begin
              sum_r  <= sum_add;
              bcnt_r <= bcnt_inc;
            end
          end
        end
        ST_WRITE: begin
          wi_r   <= wi_r + HIST_AW'(1);
          last_r <= now_r;
          if (ec_r < CNT_W'(HIST_DEPTH)) ec_r <= ec_r + CNT_W'(1);
        end
        ST_SCALE: begin
          est_r     <= est_new;
          running_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // per-item work registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        event_r <= EV_NONE;
        now_r   <= now_in;
        quo_r   <= sum_add;
        dvs_r   <= bcnt_inc;
        rem_r   <= '0;
        dstep_r <= '0;
      end
      ST_DIV: begin
        rem_r   <= rem_step;
        quo_r   <= quo_step;
        dstep_r <= dstep_r + DIV_CW'(1);
        avg_r   <= quo_step[EST_W-1:0];
      end
      ST_DECIDE: event_r <= reject ? EV_REJECTED : EV_STORED;
      ST_WRITE: begin
        old_r    <= hist_q_r;
        fi_r     <= '0;
        pos_r    <= HIST_AW'(ec_r);
        dir_up_r <= 1'b0;
      end
      ST_FIND: begin
        if (match) begin
          pos_r    <= fi_r;
          dir_up_r <= go_up;
        end else begin
          fi_r <= fi_r + HIST_AW'(1);
        end
      end
      ST_MOVE: begin
        if (slide) pos_r <= dir_up_r ? pos_r + HIST_AW'(1) : pos_r - HIST_AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_est_r   <= est_r;
          out_ready_r <= running_r;
          out_event_r <= event_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_est_r;
  assign out_tuser  = {out_event_r, out_ready_r};

endmodule

/* hdl/pnft_checker.sv */
module pnft_checker import pnft_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // rejection only once the estimate exists
  a_reject_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == EV_REJECTED |-> out_tuser[0])
    else $error("entry rejected before first estimate");

  // no estimate before the tracker is ready
  a_boot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("nonzero estimate while not ready");

endmodule

bind percentile_noise_floor_tracker pnft_checker u_pnft_checker (.*);
